>>> hw/rtl/ami_pkg.sv
// ============================================================================
// ami_pkg
// Shared types and constants for the 3x4 affine matrix inverse.
// ============================================================================
package ami_pkg;

    // Fixed-point format of every entry.
    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;

    // Exact intermediate widths: cofactors, then determinant and translation sums.
    localparam int COFW = 2 * EW + 2;
    localparam int SUMW = 3 * EW + 2;

    // Divider widths: signed numerator, dividend, divisor, quotient, remainder.
    localparam int NUMW = SUMW + FRAC_BITS;
    localparam int NW   = NUMW + 1;
    localparam int DW   = SUMW;
    localparam int QW   = EW;
    localparam int RW   = DW + QW;

    // Entry counts and queue depths.
    localparam int NCOF     = 9;
    localparam int NENT     = 12;
    localparam int MQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    // Saturation limits.
    localparam logic [EW-1:0] LIM_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] LIM_NEG = {1'b1, {(EW-1){1'b0}}};

    // One input matrix.
    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a03;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a13;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
        logic signed [EW-1:0] a23;
    } matrix_t;

    // One result entry.
    typedef struct packed {
        logic [3:0]           entry_index;
        logic signed [EW-1:0] entry_value;
        logic                 singular;
        logic                 last;
    } result_t;

    // Adjugate, translation numerators and determinant of one matrix.
    typedef struct packed {
        logic [NCOF-1:0][COFW-1:0] cof;
        logic [2:0][SUMW-1:0]      tr;
        logic [SUMW-1:0]           det;
    } adj_t;

    // Control tag that travels with each division.
    typedef struct packed {
        logic [3:0] entry_index;
        logic       singular;
        logic       last;
    } tag_t;

    // One division request.
    typedef struct packed {
        logic signed [NUMW-1:0] num;
        logic signed [SUMW-1:0] det;
        tag_t                   tag;
    } div_op_t;

endpackage

>>> hw/rtl/affine_matrix_inverse_3x4.sv
// ============================================================================
// affine_matrix_inverse_3x4
// Throughput: a matrix needs twelve divisions in the single divider pipeline,
// which takes one quotient per cycle while the output queue has room; a singular
// matrix needs a single division and is bounded by the two reserved middle-queue slots.
// Reset: asynchronous, active low; clears all queues and valid bits.
// ============================================================================
module affine_matrix_inverse_3x4 (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ami_pkg::matrix_t matrix,
    output logic             empty,
    input  logic             pop,
    output ami_pkg::result_t entry
);

    localparam int MQ_AW = $clog2(ami_pkg::MQ_DEPTH);
    localparam int MQ_CW = $clog2(ami_pkg::MQ_DEPTH + 1);

    logic             take;
    logic             front_done;
    ami_pkg::adj_t    front_adj;
    logic             head_pop;

    ami_pkg::adj_t    mq_mem [ami_pkg::MQ_DEPTH];
    logic [MQ_AW-1:0] mq_wr_reg, mq_rd_reg;
    logic [MQ_CW-1:0] mq_cnt_reg;
    logic [MQ_CW-1:0] cred_reg;

    // A matrix is taken only when the middle queue has a slot reserved for it.
    assign full = cred_reg == MQ_CW'(ami_pkg::MQ_DEPTH);
    assign take = push && !full;

    ami_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .matrix (matrix),
        .done   (front_done),
        .adj    (front_adj)
    );

    // Reservation count and middle queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cred_reg   <= '0;
            mq_wr_reg  <= '0;
            mq_rd_reg  <= '0;
            mq_cnt_reg <= '0;
        end
        else
        begin
            if (take && !head_pop)
            begin
                cred_reg <= cred_reg + MQ_CW'(1);
            end
            else if (head_pop && !take)
            begin
                cred_reg <= cred_reg - MQ_CW'(1);
            end
            if (front_done)
            begin
                mq_wr_reg <= mq_wr_reg + MQ_AW'(1);
            end
            if (head_pop)
            begin
                mq_rd_reg <= mq_rd_reg + MQ_AW'(1);
            end
            if (front_done && !head_pop)
            begin
                mq_cnt_reg <= mq_cnt_reg + MQ_CW'(1);
            end
            else if (head_pop && !front_done)
            begin
                mq_cnt_reg <= mq_cnt_reg - MQ_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_done)
        begin
            mq_mem[mq_wr_reg] <= front_adj;
        end
    end

    ami_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (mq_cnt_reg != '0),
        .head       (mq_mem[mq_rd_reg]),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .entry      (entry)
    );

endmodule

>>> hw/rtl/ami_front.sv
// ============================================================================
// ami_front
// Five-stage pipeline that forms the cofactors, determinant and translation
// numerators of one matrix exactly.
// ============================================================================
module ami_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ami_pkg::matrix_t matrix,
    output logic             done,
    output ami_pkg::adj_t    adj
);

    // Operand pairs of the eighteen 2x2 products, two per cofactor.
    localparam int PA [18] = '{5, 9, 9, 1, 1, 5, 8, 4, 0, 8, 4, 0, 4, 8, 8, 0, 0, 4};
    localparam int PB [18] = '{10, 6, 2, 10, 6, 2, 6, 10, 10, 2, 2, 6, 9, 5, 1, 9, 5, 1};

    // Cofactor and matrix entry of the twelve wide products: det, then rows.
    localparam int QC [12] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};
    localparam int QM [12] = '{0, 1, 2, 3, 7, 11, 3, 7, 11, 3, 7, 11};

    logic [11:0][ami_pkg::EW-1:0] m_in;

    logic [11:0][ami_pkg::EW-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [2*ami_pkg::EW-1:0] p2_reg [18];
    logic signed [ami_pkg::COFW-1:0] c3_reg [ami_pkg::NCOF];
    logic signed [ami_pkg::COFW-1:0] c4_reg [ami_pkg::NCOF];
    logic signed [ami_pkg::COFW-1:0] ph4_reg [12];
    logic signed [ami_pkg::COFW-2:0] pl4_reg [12];
    logic signed [ami_pkg::SUMW-1:0] full [12];
    ami_pkg::adj_t adj_next, adj_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;

    assign m_in = {matrix.a23, matrix.a22, matrix.a21, matrix.a20,
                   matrix.a13, matrix.a12, matrix.a11, matrix.a10,
                   matrix.a03, matrix.a02, matrix.a01, matrix.a00};

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= take;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Datapath stages: capture, 2x2 products, cofactors, wide split products.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m1_reg <= m_in;
        end
        m2_reg <= m1_reg;
        m3_reg <= m2_reg;
        for (int i = 0; i < 18; i++)
        begin
            p2_reg[i] <= $signed(m1_reg[PA[i]]) * $signed(m1_reg[PB[i]]);
        end
        for (int j = 0; j < ami_pkg::NCOF; j++)
        begin
            c3_reg[j] <= ami_pkg::COFW'(p2_reg[2*j]) - ami_pkg::COFW'(p2_reg[2*j+1]);
            c4_reg[j] <= c3_reg[j];
        end
        for (int q = 0; q < 12; q++)
        begin
            ph4_reg[q] <= $signed(c3_reg[QC[q]][ami_pkg::COFW-1:ami_pkg::EW])
                          * $signed(m3_reg[QM[q]]);
            pl4_reg[q] <= $signed({1'b0, c3_reg[QC[q]][ami_pkg::EW-1:0]})
                          * $signed(m3_reg[QM[q]]);
        end
        adj_reg <= adj_next;
    end

    // Recombine split products and form the sums.
    always_comb
    begin
        for (int q = 0; q < 12; q++)
        begin
            full[q] = (ami_pkg::SUMW'(ph4_reg[q]) <<< ami_pkg::EW)
                      + ami_pkg::SUMW'(pl4_reg[q]);
        end
        for (int j = 0; j < ami_pkg::NCOF; j++)
        begin
            adj_next.cof[j] = c4_reg[j];
        end
        adj_next.det = full[0] + full[1] + full[2];
        for (int r = 0; r < 3; r++)
        begin
            adj_next.tr[r] = -(full[3+3*r] + full[4+3*r] + full[5+3*r]);
        end
    end

    assign done = done_reg;
    assign adj  = adj_reg;

endmodule

>>> hw/rtl/ami_div.sv
// ============================================================================
// ami_div
// Pipelined restoring divider with round-to-nearest and saturation, one
// quotient bit per stage, advancing as a whole while enabled.
// ============================================================================
module ami_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  ami_pkg::div_op_t op,
    output logic             out_valid,
    output ami_pkg::result_t res
);

    logic [ami_pkg::NUMW-1:0] abs_num;
    logic [ami_pkg::SUMW-1:0] abs_det;

    logic [ami_pkg::NW-1:0] n1_reg;
    logic [ami_pkg::DW-1:0] d1_reg;
    logic                   neg1_reg;
    ami_pkg::tag_t          tag1_reg;
    logic                   v1_reg;

    logic [ami_pkg::RW-1:0] rs_reg  [ami_pkg::QW+1];
    logic [ami_pkg::DW-1:0] ds_reg  [ami_pkg::QW+1];
    logic [ami_pkg::QW-1:0] qs_reg  [ami_pkg::QW+1];
    logic                   negs_reg [ami_pkg::QW+1];
    logic                   ovfs_reg [ami_pkg::QW+1];
    ami_pkg::tag_t          tags_reg [ami_pkg::QW+1];
    logic                   vs_reg  [ami_pkg::QW+1];

    logic [ami_pkg::QW-1:0] q_fin;
    logic [ami_pkg::QW-1:0] lim;
    ami_pkg::result_t       res_next, res_reg;
    logic                   vf_reg;

    // Magnitudes of numerator and determinant.
    always_comb
    begin
        abs_num = op.num[ami_pkg::NUMW-1] ? ami_pkg::NUMW'(-op.num) : op.num;
        abs_det = op.det[ami_pkg::SUMW-1] ? ami_pkg::SUMW'(-op.det) : op.det;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vf_reg <= 1'b0;
            for (int s = 0; s <= ami_pkg::QW; s++)
            begin
                vs_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            vs_reg[0] <= v1_reg;
            for (int s = 0; s < ami_pkg::QW; s++)
            begin
                vs_reg[s+1] <= vs_reg[s];
            end
            vf_reg <= vs_reg[ami_pkg::QW];
        end
    end

    // Datapath: rounding bias, overflow check, then one quotient bit a stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= {abs_num, 1'b0} + ami_pkg::NW'(abs_det);
            d1_reg   <= {abs_det[ami_pkg::SUMW-2:0], 1'b0};
            neg1_reg <= op.num[ami_pkg::NUMW-1] ^ op.det[ami_pkg::SUMW-1];
            tag1_reg <= op.tag;

            rs_reg[0]   <= ami_pkg::RW'(n1_reg);
            ds_reg[0]   <= d1_reg;
            qs_reg[0]   <= '0;
            negs_reg[0] <= neg1_reg;
            ovfs_reg[0] <= ami_pkg::RW'(n1_reg) >= {d1_reg, ami_pkg::QW'(0)};
            tags_reg[0] <= tag1_reg;

            for (int s = 0; s < ami_pkg::QW; s++)
            begin
                if (rs_reg[s] >= (ami_pkg::RW'(ds_reg[s]) << (ami_pkg::QW-1-s)))
                begin
                    rs_reg[s+1] <= rs_reg[s]
                                   - (ami_pkg::RW'(ds_reg[s]) << (ami_pkg::QW-1-s));
                    qs_reg[s+1] <= qs_reg[s] | (ami_pkg::QW'(1) << (ami_pkg::QW-1-s));
                end
                else
                begin
                    rs_reg[s+1] <= rs_reg[s];
                    qs_reg[s+1] <= qs_reg[s];
                end
                ds_reg[s+1]   <= ds_reg[s];
                negs_reg[s+1] <= negs_reg[s];
                ovfs_reg[s+1] <= ovfs_reg[s];
                tags_reg[s+1] <= tags_reg[s];
            end

            res_reg <= res_next;
        end
    end

    // Saturate, apply sign, or give zero for a singular matrix.
    always_comb
    begin
        q_fin = qs_reg[ami_pkg::QW];
        lim   = negs_reg[ami_pkg::QW] ? ami_pkg::LIM_NEG : ami_pkg::LIM_POS;
        res_next.entry_index = tags_reg[ami_pkg::QW].entry_index;
        res_next.singular    = tags_reg[ami_pkg::QW].singular;
        res_next.last        = tags_reg[ami_pkg::QW].last;
        if (tags_reg[ami_pkg::QW].singular)
        begin
            res_next.entry_value = '0;
        end
        else if (ovfs_reg[ami_pkg::QW] || (q_fin > lim))
        begin
            res_next.entry_value = lim;
        end
        else if (negs_reg[ami_pkg::QW])
        begin
            res_next.entry_value = -q_fin;
        end
        else
        begin
            res_next.entry_value = q_fin;
        end
    end

    assign out_valid = vf_reg;
    assign res       = res_reg;

endmodule

>>> hw/rtl/ami_back.sv
// ============================================================================
// ami_back
// Issues the twelve divisions of each queued matrix (a single one for a singular
// matrix), runs the divider and holds finished results in a small output queue.
// ============================================================================
module ami_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  ami_pkg::adj_t    head,
    output logic             head_pop,
    input  logic             pop,
    output logic             empty,
    output ami_pkg::result_t entry
);

    localparam int OQ_AW = $clog2(ami_pkg::OQ_DEPTH);
    localparam int OQ_CW = $clog2(ami_pkg::OQ_DEPTH + 1);

    logic                 en;
    logic                 sing;
    logic                 issue;
    logic [3:0]           k_reg, k_next;
    logic [1:0]           row;
    logic [1:0]           col;
    logic [3:0]           cidx;
    ami_pkg::div_op_t     op_next, op_reg;
    logic                 opv_reg;

    logic                 div_valid;
    ami_pkg::result_t     div_res;

    ami_pkg::result_t     oq_mem [ami_pkg::OQ_DEPTH];
    logic [OQ_AW-1:0]     oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0]     oq_cnt_reg;
    logic                 oq_push, oq_pop;

    // The divider advances while the output queue has room.
    assign en    = oq_cnt_reg != OQ_CW'(ami_pkg::OQ_DEPTH);
    assign sing  = head.det == '0;
    assign issue = head_valid && en;
    assign head_pop = issue && (sing || k_reg == 4'(ami_pkg::NENT - 1));

    // Select the numerator of the current entry.
    always_comb
    begin
        row  = k_reg[3:2];
        col  = k_reg[1:0];
        cidx = (col == 2'd3) ? 4'd0 : 4'({2'b00, row} * 4'd3 + {2'b00, col});
        if (col == 2'd3)
        begin
            op_next.num = ami_pkg::NUMW'($signed(head.tr[row])) <<< ami_pkg::FRAC_BITS;
        end
        else
        begin
            op_next.num = ami_pkg::NUMW'($signed(head.cof[cidx]))
                          <<< (2 * ami_pkg::FRAC_BITS);
        end
        op_next.det = $signed(head.det);
        if (sing)
        begin
            op_next.tag.entry_index = 4'd0;
            op_next.tag.singular    = 1'b1;
            op_next.tag.last        = 1'b1;
        end
        else
        begin
            op_next.tag.entry_index = k_reg;
            op_next.tag.singular    = 1'b0;
            op_next.tag.last        = k_reg == 4'(ami_pkg::NENT - 1);
        end
        if (head_pop)
        begin
            k_next = 4'd0;
        end
        else if (issue)
        begin
            k_next = k_reg + 4'd1;
        end
        else
        begin
            k_next = k_reg;
        end
    end

    // Entry counter and issue register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= 4'd0;
            opv_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (en)
            begin
                opv_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= op_next;
        end
    end

    ami_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (opv_reg),
        .op        (op_reg),
        .out_valid (div_valid),
        .res       (div_res)
    );

    // Output queue.
    assign oq_push = div_valid && en;
    assign oq_pop  = pop && (oq_cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + OQ_AW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_AW'(1);
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + OQ_CW'(1);
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - OQ_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= div_res;
        end
    end

    assign empty = oq_cnt_reg == '0;
    assign entry = oq_mem[oq_rd_reg];

endmodule
